@@ rtl/core/mwd_pkg.sv @@
// Package for the modem word deframer: opcodes, result kinds, register
// indexes and default sizes. No dependencies.
`default_nettype none

package mwd_pkg;

   localparam int unsigned MAX_WORDS_DEF = 10;

   // request opcodes
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_CONSUME = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_FLOAT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_HS_SYNC   = 3'd0;
   localparam logic [2:0] CSR_ACK_CODE  = 3'd1;
   localparam logic [2:0] CSR_PER_SYNC  = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [2:0] CSR_COUNT0    = 3'd4;
   localparam logic [2:0] CSR_COUNT1    = 3'd5;
   localparam logic [2:0] CSR_COUNT2    = 3'd6;
   localparam logic [2:0] CSR_COUNT3    = 3'd7;

   localparam logic [2:0] MAX_FLOATS = 3'd5;
   localparam logic [15:0] TICK_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

@@ rtl/core/mwd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mwd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 5,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/modem_word_deframer_top.sv @@
// Modem word deframer top level: byte pairing, word classification,
// message assembly and float readout. Uses mwd_pkg and mwd_ram.
//
// Usage:
//   req_* carries one item per transfer: a received byte, a time tick or a
//   "pending command consumed" notice. rsp_* carries results: acknowledges,
//   persistent commands and message floats (rsp_last marks the final float
//   of a message and every single result). csr_* writes one register per
//   transfer; csr_ready is always high.
//   A result caused by a byte appears in the output register in the cycle
//   after the byte's transfer. When the last payload word of a message
//   arrives, the pairs are read back from the payload RAM one float at a
//   time, each through an address state (ST_READ) and an emit state
//   (ST_EMIT); the input is stalled until the message's last float has
//   been put in the output register.
//   While the output register holds an untaken result and rsp_stall is
//   high, req_stall is high; no result is ever dropped.
//   Reset (synchronous, active high) restores register defaults and clears
//   all control state but the held low word; the payload RAM needs no clearing,
//   entries are read only after they were written in the current message.
`default_nettype none

module modem_word_deframer_top #(
   parameter int unsigned MAX_WORDS = mwd_pkg::MAX_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_msg_type,
   output logic [9:0]       rsp_msg_ident,
   output logic [11:0]      rsp_command,
   output logic [31:0]      rsp_float_bits,
   output logic [2:0]       rsp_float_index,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned FDEPTH = (MAX_WORDS / 2 > 0) ? MAX_WORDS / 2 : 1;
   localparam int unsigned FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int unsigned RCW    = $clog2(MAX_WORDS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // configuration
   logic [3:0]  hs_sync_ff, ack_code_ff, per_sync_ff;
   logic [15:0] timeout_ff;
   logic [2:0]  count_ff [4];

   // control state
   logic [1:0]     state_ff, state_in;
   logic           have_low_ff, have_low_in;
   logic [7:0]     low_byte_ff, low_byte_in;
   logic           rcv_ff, rcv_in;
   logic [1:0]     cur_type_ff, cur_type_in;
   logic [9:0]     cur_ident_ff, cur_ident_in;
   logic [2:0]     nfl_ff, nfl_in;
   logic [RCW-1:0] rcnt_ff, rcnt_in;
   logic [15:0]    low_word_ff, low_word_in;
   logic [15:0]    idle_ff, idle_in;
   logic           pend_ff, pend_in;
   logic [11:0]    last_cmd_ff, last_cmd_in;
   logic [2:0]     rd_idx_ff, rd_idx_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  o_kind_ff, o_kind_in;
   logic [1:0]  o_type_ff, o_type_in;
   logic [9:0]  o_ident_ff, o_ident_in;
   logic [11:0] o_cmd_ff, o_cmd_in;
   logic [31:0] o_bits_ff, o_bits_in;
   logic [2:0]  o_idx_ff, o_idx_in;
   logic        o_last_ff, o_last_in;

   logic           out_free, accept;
   logic [15:0]    word;
   logic [3:0]     cls;
   logic [2:0]     hs_n;
   logic           hs_ok, stale;
   logic [RCW-1:0] rcnt_nx;
   logic           msg_done;
   logic           ram_we;
   logic [31:0]    ram_rd_data;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign word    = {req_byte_value, low_byte_ff};
   assign cls     = word[15:12];
   assign hs_n    = count_ff[word[11:10]];
   assign hs_ok   = (hs_n != 3'd0) && (hs_n <= mwd_pkg::MAX_FLOATS)
                    && ({2'b00, hs_n, 1'b0} <= 6'(MAX_WORDS));
   assign stale   = rcv_ff && (idle_ff > timeout_ff);
   assign rcnt_nx = rcnt_ff + RCW'(1);
   assign msg_done = (rcnt_nx == RCW'({nfl_ff, 1'b0}));

   always_comb begin
      state_in     = state_ff;
      have_low_in  = have_low_ff;
      low_byte_in  = low_byte_ff;
      rcv_in       = rcv_ff;
      cur_type_in  = cur_type_ff;
      cur_ident_in = cur_ident_ff;
      nfl_in       = nfl_ff;
      rcnt_in      = rcnt_ff;
      low_word_in  = low_word_ff;
      idle_in      = idle_ff;
      pend_in      = pend_ff;
      last_cmd_in  = last_cmd_ff;
      rd_idx_in    = rd_idx_ff;
      ram_we       = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      o_kind_in    = o_kind_ff;
      o_type_in    = o_type_ff;
      o_ident_in   = o_ident_ff;
      o_cmd_in     = o_cmd_ff;
      o_bits_in    = o_bits_ff;
      o_idx_in     = o_idx_ff;
      o_last_in    = o_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mwd_pkg::OP_BYTE: begin
                     if (!have_low_ff) begin
                        low_byte_in = req_byte_value;
                        have_low_in = 1'b1;
                     end else begin
                        have_low_in = 1'b0;
                        if (!rcv_ff && cls == ack_code_ff) begin
                           out_valid_in = 1'b1;
                           o_kind_in    = mwd_pkg::KIND_ACK;
                           o_type_in    = word[11:10];
                           o_ident_in   = word[9:0];
                           o_cmd_in     = '0;
                           o_bits_in    = '0;
                           o_idx_in     = '0;
                           o_last_in    = 1'b1;
                        end else if (!rcv_ff && cls == per_sync_ff) begin
                           // a repeat of the still-pending command is swallowed
                           if (!(pend_ff && last_cmd_ff == word[11:0])) begin
                              last_cmd_in  = word[11:0];
                              pend_in      = 1'b1;
                              out_valid_in = 1'b1;
                              o_kind_in    = mwd_pkg::KIND_CMD;
                              o_type_in    = '0;
                              o_ident_in   = '0;
                              o_cmd_in     = word[11:0];
                              o_bits_in    = '0;
                              o_idx_in     = '0;
                              o_last_in    = 1'b1;
                           end
                        end else begin
                           idle_in = '0;
                           if (!rcv_ff || stale) begin
                              rcv_in  = 1'b0;
                              rcnt_in = '0;
                              if (cls == hs_sync_ff) begin
                                 cur_type_in  = word[11:10];
                                 cur_ident_in = word[9:0];
                                 nfl_in       = hs_n;
                                 rcv_in       = hs_ok;
                              end
                           end else begin
                              // even word held, odd word completes a float pair
                              if (!rcnt_ff[0]) begin
                                 low_word_in = word;
                              end else begin
                                 ram_we = 1'b1;
                              end
                              rcnt_in = rcnt_nx;
                              if (msg_done) begin
                                 rcv_in    = 1'b0;
                                 rcnt_in   = '0;
                                 rd_idx_in = '0;
                                 state_in  = ST_READ;
                              end
                           end
                        end
                     end
                  end
                  mwd_pkg::OP_TICK: begin
                     if (idle_ff != mwd_pkg::TICK_MAX) begin
                        idle_in = idle_ff + 16'd1;
                     end
                  end
                  mwd_pkg::OP_CONSUME: begin
                     pend_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               o_kind_in    = mwd_pkg::KIND_FLOAT;
               o_type_in    = cur_type_ff;
               o_ident_in   = cur_ident_ff;
               o_cmd_in     = '0;
               o_bits_in    = ram_rd_data;
               o_idx_in     = rd_idx_ff;
               o_last_in    = (rd_idx_ff + 3'd1 == nfl_ff);
               if (rd_idx_ff + 3'd1 == nfl_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 3'd1;
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   mwd_ram #(
      .WIDTH (32),
      .DEPTH (FDEPTH)
   ) u_payload (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (FAW'(rcnt_ff >> 1)),
      .wr_data ({word, low_word_ff}),
      .rd_addr (FAW'(rd_idx_ff)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_sync_ff  <= 4'd10;
         ack_code_ff <= 4'd11;
         per_sync_ff <= 4'd12;
         timeout_ff  <= 16'd1000;
         count_ff[0] <= 3'd2;
         count_ff[1] <= 3'd4;
         count_ff[2] <= 3'd5;
         count_ff[3] <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mwd_pkg::CSR_HS_SYNC:  hs_sync_ff  <= csr_wdata[3:0];
            mwd_pkg::CSR_ACK_CODE: ack_code_ff <= csr_wdata[3:0];
            mwd_pkg::CSR_PER_SYNC: per_sync_ff <= csr_wdata[3:0];
            mwd_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata;
            mwd_pkg::CSR_COUNT0:   count_ff[0] <= csr_wdata[2:0];
            mwd_pkg::CSR_COUNT1:   count_ff[1] <= csr_wdata[2:0];
            mwd_pkg::CSR_COUNT2:   count_ff[2] <= csr_wdata[2:0];
            mwd_pkg::CSR_COUNT3:   count_ff[3] <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_low_ff  <= 1'b0;
         low_byte_ff  <= '0;
         rcv_ff       <= 1'b0;
         cur_type_ff  <= '0;
         cur_ident_ff <= '0;
         nfl_ff       <= '0;
         rcnt_ff      <= '0;
         idle_ff      <= '0;
         pend_ff      <= 1'b0;
         last_cmd_ff  <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_low_ff  <= have_low_in;
         low_byte_ff  <= low_byte_in;
         rcv_ff       <= rcv_in;
         cur_type_ff  <= cur_type_in;
         cur_ident_ff <= cur_ident_in;
         nfl_ff       <= nfl_in;
         rcnt_ff      <= rcnt_in;
         idle_ff      <= idle_in;
         pend_ff      <= pend_in;
         last_cmd_ff  <= last_cmd_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_word_ff <= low_word_in;
      o_kind_ff   <= o_kind_in;
      o_type_ff   <= o_type_in;
      o_ident_ff  <= o_ident_in;
      o_cmd_ff    <= o_cmd_in;
      o_bits_ff   <= o_bits_in;
      o_idx_ff    <= o_idx_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = o_kind_ff;
   assign rsp_msg_type    = o_type_ff;
   assign rsp_msg_ident   = o_ident_ff;
   assign rsp_command     = o_cmd_ff;
   assign rsp_float_bits  = o_bits_ff;
   assign rsp_float_index = o_idx_ff;
   assign rsp_last        = o_last_ff;

endmodule

`default_nettype wire

@@ rtl/core/mwd_checker.sv @@
// Port-level checks for the modem word deframer, bound to the top level.
// Uses mwd_pkg.
`default_nettype none

module mwd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_kind,
   input wire logic [1:0]  rsp_msg_type,
   input wire logic [9:0]  rsp_msg_ident,
   input wire logic [11:0] rsp_command,
   input wire logic [31:0] rsp_float_bits,
   input wire logic [2:0]  rsp_float_index,
   input wire logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_float_bits)
         && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != mwd_pkg::KIND_FLOAT |-> rsp_last)
      else $error("ack or command without last");

   a_cmd_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mwd_pkg::KIND_CMD |->
         rsp_msg_type == 2'd0 && rsp_msg_ident == 10'd0 && rsp_float_bits == 32'd0)
      else $error("command result carries stray fields");

   a_float_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mwd_pkg::KIND_FLOAT |->
         rsp_command == 12'd0 && rsp_float_index < mwd_pkg::MAX_FLOATS)
      else $error("float result out of range");

endmodule

bind modem_word_deframer_top mwd_checker u_mwd_checker (.*);

`default_nettype wire

@@ test/modem_word_deframer_top_tb.sv @@
// Self-checking testbench for modem_word_deframer_top: random and directed byte, tick and
// consume traffic against a scoreboard that models the deframer.
// Depends on mwd_pkg and the RTL of modem_word_deframer_top.
`default_nettype none

typedef struct packed {
   logic [1:0]  kind;
   logic [1:0]  msg_type;
   logic [9:0]  msg_ident;
   logic [11:0] command;
   logic [31:0] float_bits;
   logic [2:0]  float_index;
   logic        last;
} deframer_result_type;

class deframer_scoreboard;
   localparam int WORDS = mwd_pkg::MAX_WORDS_DEF;

   // register mirror
   logic [3:0]  hs_sync;
   logic [3:0]  ack_code;
   logic [3:0]  per_sync;
   logic [15:0] timeout_ticks;
   logic [2:0]  float_count [4];

   // deframer state
   logic        have_low;
   logic [7:0]  low_byte;
   logic        receiving;
   logic [1:0]  cur_type;
   logic [9:0]  cur_ident;
   logic [3:0]  words_due;
   logic [3:0]  words_seen;
   logic [15:0] payload [WORDS];
   logic [15:0] idle_ticks;
   logic        cmd_pending;
   logic [11:0] last_cmd;

   deframer_result_type pending_q[$];
   int failures;

   function new();
      hs_sync = 4'd10;
      ack_code = 4'd11;
      per_sync = 4'd12;
      timeout_ticks = 16'd1000;
      float_count[0] = 3'd2;
      float_count[1] = 3'd4;
      float_count[2] = 3'd5;
      float_count[3] = 3'd0;
      have_low = 1'b0;
      low_byte = '0;
      receiving = 1'b0;
      cur_type = '0;
      cur_ident = '0;
      words_due = '0;
      words_seen = '0;
      idle_ticks = '0;
      cmd_pending = 1'b0;
      last_cmd = '0;
      failures = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         mwd_pkg::CSR_HS_SYNC:  hs_sync = data[3:0];
         mwd_pkg::CSR_ACK_CODE: ack_code = data[3:0];
         mwd_pkg::CSR_PER_SYNC: per_sync = data[3:0];
         mwd_pkg::CSR_TIMEOUT:  timeout_ticks = data;
         mwd_pkg::CSR_COUNT0:   float_count[0] = data[2:0];
         mwd_pkg::CSR_COUNT1:   float_count[1] = data[2:0];
         mwd_pkg::CSR_COUNT2:   float_count[2] = data[2:0];
         mwd_pkg::CSR_COUNT3:   float_count[3] = data[2:0];
         default: begin
         end
      endcase
   endfunction

   function void add_expected(logic [1:0] kind, logic [1:0] typ, logic [9:0] ident,
                              logic [11:0] cmd, logic [31:0] bits, logic [2:0] idx,
                              logic lst);
      deframer_result_type r;
      r.kind = kind;
      r.msg_type = typ;
      r.msg_ident = ident;
      r.command = cmd;
      r.float_bits = bits;
      r.float_index = idx;
      r.last = lst;
      pending_q.push_back(r);
   endfunction

   function void drop_message();
      receiving = 1'b0;
      words_due = '0;
      words_seen = '0;
   endfunction

   function void take_word(logic [15:0] w);
      logic [3:0] cls;
      int n;
      cls = w[15:12];
      if (!receiving) begin
         if (cls == ack_code) begin
            add_expected(mwd_pkg::KIND_ACK, w[11:10], w[9:0], '0, '0, '0, 1'b1);
            return;
         end
         if (cls == per_sync) begin
            // repeat of the command software has not consumed yet
            if (cmd_pending && last_cmd == w[11:0])
               return;
            last_cmd = w[11:0];
            cmd_pending = 1'b1;
            add_expected(mwd_pkg::KIND_CMD, '0, '0, w[11:0], '0, '0, 1'b1);
            return;
         end
      end
      if (receiving && idle_ticks > timeout_ticks)
         drop_message();
      idle_ticks = '0;
      if (!receiving) begin
         if (cls == hs_sync) begin
            cur_type = w[11:10];
            cur_ident = w[9:0];
            n = int'(float_count[w[11:10]]);
            words_due = 4'((2 * n) & 'hF);
            words_seen = '0;
            receiving = (n != 0 && n <= 5 && 2 * n <= WORDS);
         end
         return;
      end
      if (words_seen >= words_due || int'(words_seen) >= WORDS) begin
         drop_message();
         return;
      end
      payload[words_seen] = w;
      words_seen = words_seen + 4'd1;
      if (words_seen == words_due) begin
         n = int'(words_due) / 2;
         for (int i = 0; i < n && i < 5; i++)
            add_expected(mwd_pkg::KIND_FLOAT, cur_type, cur_ident, '0,
                         {payload[2 * i + 1], payload[2 * i]}, 3'(i), (i + 1 == n));
         drop_message();
      end
   endfunction

   function void note_input(logic [1:0] op, logic [7:0] b);
      if (op == mwd_pkg::OP_BYTE) begin
         if (!have_low) begin
            low_byte = b;
            have_low = 1'b1;
         end else begin
            have_low = 1'b0;
            take_word({b, low_byte});
         end
      end else if (op == mwd_pkg::OP_TICK) begin
         if (idle_ticks != mwd_pkg::TICK_MAX)
            idle_ticks = idle_ticks + 16'd1;
      end else if (op == mwd_pkg::OP_CONSUME) begin
         cmd_pending = 1'b0;
      end
   endfunction

   function string fmt_result(deframer_result_type r);
      return $sformatf("kind=%0d type=%0d id=%0d cmd=%03h bits=%08h idx=%0d last=%0d",
                       r.kind, r.msg_type, r.msg_ident, r.command, r.float_bits,
                       r.float_index, r.last);
   endfunction

   function void check_result(deframer_result_type got);
      deframer_result_type want;
      if (pending_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: %s", fmt_result(got));
         return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
          got.msg_ident !== want.msg_ident || got.command !== want.command ||
          got.float_bits !== want.float_bits || got.float_index !== want.float_index ||
          got.last !== want.last) begin
         failures++;
         if (failures <= 10) begin
            $display("mismatch expected: %s", fmt_result(want));
            $display("         actual:   %s", fmt_result(got));
         end
      end
   endfunction
endclass

module modem_word_deframer_top_tb;

   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_PAD = 16;
   localparam int IDLE_LIMIT = 3000;
   localparam int PHASE_ITEMS = 60;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = mwd_pkg::OP_BYTE;
   logic [7:0]  req_byte_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_msg_type;
   logic [9:0]  rsp_msg_ident;
   logic [11:0] rsp_command;
   logic [31:0] rsp_float_bits;
   logic [2:0]  rsp_float_index;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   deframer_scoreboard sb = new();
   deframer_result_type seen_rsp;

   // generator's copy of the register settings
   logic [3:0]  cfg_hs = 4'd10;
   logic [3:0]  cfg_ack = 4'd11;
   logic [3:0]  cfg_per = 4'd12;
   int          cfg_timeout = 1000;
   logic [2:0]  cfg_count [4] = '{3'd2, 3'd4, 3'd5, 3'd0};

   logic        req_up = 1'b0;
   bit          byte_odd = 1'b0;
   int          burst_left = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          stall_cycle = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always #CLK_HALF clock = ~clock;

   modem_word_deframer_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_msg_type(rsp_msg_type),
      .rsp_msg_ident(rsp_msg_ident),
      .rsp_command(rsp_command),
      .rsp_float_bits(rsp_float_bits),
      .rsp_float_index(rsp_float_index),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // transfer monitor: values read here are the ones sampled at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            sb.note_input(req_opcode, req_byte_value);
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.kind = rsp_kind;
            seen_rsp.msg_type = rsp_msg_type;
            seen_rsp.msg_ident = rsp_msg_ident;
            seen_rsp.command = rsp_command;
            seen_rsp.float_bits = rsp_float_bits;
            seen_rsp.float_index = rsp_float_index;
            seen_rsp.last = rsp_last;
            sb.check_result(seen_rsp);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("modem_word_deframer_top regression: fail");
         $finish;
      end
   end

   // receiver back-pressure, with the pattern picked at random from four modes
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 150 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_cycle % 7) < 3;
      endcase
   end

   task automatic drop_valid();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_up = 1'b1;
      req_opcode <= op;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      if (op == mwd_pkg::OP_BYTE)
         byte_odd = ~byte_odd;
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   // optionally slips a tick or consume between the two bytes of a word
   task automatic send_word(input logic [15:0] w, input bit split);
      send_item(mwd_pkg::OP_BYTE, w[7:0]);
      if (split)
         send_item($urandom_range(0, 1) ? mwd_pkg::OP_TICK : mwd_pkg::OP_CONSUME,
                   8'($urandom));
      send_item(mwd_pkg::OP_BYTE, w[15:8]);
   endtask

   task automatic realign();
      if (byte_odd)
         send_item(mwd_pkg::OP_BYTE, 8'($urandom));
   endtask

   // waits on clock edges until no result is expected, so the last transfer has reached the scoreboard
   task automatic wait_drained();
      drop_valid();
      do @(posedge clock); while (sb.pending_q.size() != 0);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(input logic [3:0] hs, input logic [3:0] ack,
                              input logic [3:0] per, input logic [15:0] timeout,
                              input logic [2:0] c0, input logic [2:0] c1,
                              input logic [2:0] c2, input logic [2:0] c3);
      wait_drained();
      repeat (DRAIN_PAD) @(posedge clock);
      write_csr(mwd_pkg::CSR_HS_SYNC, {12'($urandom), hs});
      write_csr(mwd_pkg::CSR_ACK_CODE, {12'($urandom), ack});
      write_csr(mwd_pkg::CSR_PER_SYNC, {12'($urandom), per});
      write_csr(mwd_pkg::CSR_TIMEOUT, timeout);
      write_csr(mwd_pkg::CSR_COUNT0, {13'd0, c0});
      write_csr(mwd_pkg::CSR_COUNT1, {13'd0, c1});
      write_csr(mwd_pkg::CSR_COUNT2, {13'd0, c2});
      write_csr(mwd_pkg::CSR_COUNT3, {13'd0, c3});
      csr_valid <= 1'b0;
      cfg_hs = hs;
      cfg_ack = ack;
      cfg_per = per;
      cfg_timeout = int'(timeout);
      cfg_count = '{c0, c1, c2, c3};
   endtask

   // handshake plus payload, sometimes cut short, with ticks between words
   task automatic send_frame();
      logic [1:0] t;
      int n;
      int words;
      int tick_max;
      realign();
      t = 2'($urandom);
      n = int'(cfg_count[t]);
      words = (n >= 1 && n <= 5) ? 2 * n : 0;
      if (words > 0 && $urandom_range(0, 9) == 0)
         words = $urandom_range(0, words - 1);
      tick_max = cfg_timeout < 6 ? cfg_timeout + 2 : 3;
      send_word({cfg_hs, t, 10'($urandom)}, 1'b0);
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, tick_max)) send_item(mwd_pkg::OP_TICK, 8'($urandom));
         send_word(16'($urandom), $urandom_range(0, 11) == 0);
      end
   endtask

   task automatic random_traffic(input int n);
      int target;
      int pick;
      logic [11:0] cmd;
      target = items_sent + n;
      cmd = 12'($urandom);
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_frame();
         end else if (pick < 62) begin
            realign();
            send_word({cfg_ack, 12'($urandom)}, 1'b0);
         end else if (pick < 77) begin
            realign();
            if ($urandom_range(0, 2) != 0)
               cmd = 12'($urandom);
            send_word({cfg_per, cmd}, $urandom_range(0, 7) == 0);
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 4)) send_item(mwd_pkg::OP_TICK, 8'($urandom));
         end else if (pick < 91) begin
            send_item(mwd_pkg::OP_CONSUME, 8'($urandom));
         end else if (pick < 95) begin
            send_item(mwd_pkg::OP_BYTE, 8'($urandom));
         end else if (pick < 97) begin
            send_item(OP_UNUSED, 8'($urandom));
         end else if (pick < 99) begin
            send_word(16'($urandom), 1'b0);
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset defaults
      send_word(16'hBFFF, 1'b0);
      send_word(16'hB000, 1'b0);
      send_word(16'hCABC, 1'b0);
      send_word(16'hCABC, 1'b0);     // repeat while pending: no result
      send_item(mwd_pkg::OP_CONSUME, 8'h00);
      send_word(16'hCABC, 1'b0);
      send_item(OP_UNUSED, 8'hFF);
      send_word(16'hAC00, 1'b0);     // type 3 has zero floats: dropped
      send_word(16'hA3FF, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_item(mwd_pkg::OP_TICK, 8'hA5);
      send_word(16'h0000, 1'b0);
      send_word(16'h00FF, 1'b0);
      send_word(16'hFF00, 1'b0);
      wait_drained();

      random_traffic(PHASE_ITEMS);
      // zero timeout and an out-of-range count
      load_config(4'd0, 4'd15, 4'd7, 16'd0, 3'd1, 3'd2, 3'd3, 3'd7);
      random_traffic(PHASE_ITEMS);
      load_config(4'd15, 4'd0, 4'd14, 16'hFFFF, 3'd5, 3'd5, 3'd5, 3'd5);
      random_traffic(PHASE_ITEMS);
      load_config(4'd3, 4'd4, 4'd5, 16'd3, 3'd0, 3'd1, 3'd5, 3'd2);
      random_traffic(PHASE_ITEMS);
      // all classes equal: ack decode wins while idle
      load_config(4'd9, 4'd9, 4'd9, 16'd2, 3'd3, 3'd4, 3'd1, 3'd6);
      random_traffic(PHASE_ITEMS);
      load_config(4'd10, 4'd11, 4'd12, 16'd1000, 3'd2, 3'd4, 3'd5, 3'd0);
      random_traffic(PHASE_ITEMS);

      wait_drained();
      repeat (DRAIN_PAD) @(posedge clock);
      if (sb.failures == 0 && sb.pending_q.size() == 0)
         $display("modem_word_deframer_top regression: pass");
      else
         $display("modem_word_deframer_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
